FILE: src/srq_pkg.sv
package srq_pkg;

    localparam logic [2:0] REG_VALUE_KIND = 3'd0;
    localparam logic [2:0] REG_EVENT_MASK = 3'd1;
    localparam logic [2:0] REG_PERIOD     = 3'd2;
    localparam logic [2:0] REG_UPPER      = 3'd3;
    localparam logic [2:0] REG_LOWER      = 3'd4;

    localparam logic [1:0] KIND_BOOL  = 2'd0;
    localparam logic [1:0] KIND_INT   = 2'd1;
    localparam logic [1:0] KIND_FLOAT = 2'd2;

    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_FORCE   = 2'd1;
    localparam logic [1:0] FUNC_CONFIRM = 2'd2;

    localparam logic [9:0] MS_PER_SECOND = 10'd1000;

    localparam logic [2:0] BYTES_NONE  = 3'd0;
    localparam logic [2:0] BYTES_BOOL  = 3'd1;
    localparam logic [2:0] BYTES_WORD  = 3'd4;

    function automatic logic is_nan(input logic [31:0] a);
        return (a[30:23] == 8'hff) && (a[22:0] != 23'd0);
    endfunction

    // IEEE a < b, false if either is NaN; +0 equals -0
    function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
        logic both_zero;
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        if (is_nan(a) || is_nan(b) || both_zero) return 1'b0;
        if (a[31] != b[31]) return a[31];
        if (a[31]) return a[30:0] > b[30:0];
        return a[30:0] < b[30:0];
    endfunction

    function automatic logic flt_eq(input logic [31:0] a, input logic [31:0] b);
        if (is_nan(a) || is_nan(b)) return 1'b0;
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) return 1'b1;
        return a == b;
    endfunction

endpackage

FILE: src/sensor_report_qualifier.sv
// Channel   Dir  Transfer when             Payload
// in        in   i_valid & o_ready         i_func, i_sample_bits, i_now_ms, i_want_ack
// out       out  o_valid & i_ready         o_report, o_report_bits, o_report_bytes
// cfg       in   psel & penable & pwrite   paddr, pwdata (pready always high)
//
// One item per cycle: the decision and state update are one combinational pass
// from the accepted item into the output register; state updates on acceptance.
// The result shows in the next cycle. A new item is taken whenever the output
// register is empty or is drained in the same cycle. Synchronous active-low reset
// sets control and state registers to their reset values and empties the output.
module sensor_report_qualifier
    import srq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_sample_bits,
    input  logic [31:0] i_now_ms,
    input  logic        i_want_ack,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_report,
    output logic [31:0] o_report_bits,
    output logic [2:0]  o_report_bytes,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [1:0]  r_kind;
    logic [3:0]  r_mask;
    logic [15:0] r_period;
    logic [31:0] r_upper, r_lower;
    logic [31:0] r_held, n_held;
    logic [31:0] r_last_ms, n_last_ms;
    logic        r_pending, n_pending;
    logic        r_above, n_above;
    logic        r_below, n_below;
    logic        r_out_valid;
    logic        r_out_report, n_out_report;
    logic [31:0] r_out_bits;
    logic [2:0]  r_out_bytes, n_out_bytes;

    logic        in_xfer, cfg_wr;
    logic [2:0]  reg_idx;
    logic [25:0] period_ms;
    logic        timeout, chg, up, low, fire;

    assign o_ready = !r_out_valid || i_ready;
    assign in_xfer = i_valid && o_ready;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb begin
        unique case (reg_idx)
            REG_VALUE_KIND: prdata = {30'd0, r_kind};
            REG_EVENT_MASK: prdata = {28'd0, r_mask};
            REG_PERIOD:     prdata = {16'd0, r_period};
            REG_UPPER:      prdata = r_upper;
            REG_LOWER:      prdata = r_lower;
            default:        prdata = 32'd0;
        endcase
    end

    assign period_ms = r_period * MS_PER_SECOND;

    always_comb begin
        n_held = r_held;
        n_last_ms = r_last_ms;
        n_pending = r_pending;
        n_above = r_above;
        n_below = r_below;
        n_out_report = 1'b0;
        n_out_bytes = BYTES_NONE;
        timeout = r_mask[1] && ((i_now_ms - r_last_ms) >= {6'd0, period_ms});
        chg = 1'b0;
        up = 1'b0;
        low = 1'b0;
        fire = 1'b0;
        unique case (r_kind)
            KIND_INT: begin
                chg = i_sample_bits != r_held;
                up  = $signed(i_sample_bits) > $signed(r_upper);
                low = $signed(i_sample_bits) < $signed(r_lower);
            end
            KIND_FLOAT: begin
                chg = !flt_eq(i_sample_bits, r_held);
                up  = flt_lt(r_upper, i_sample_bits);
                low = flt_lt(i_sample_bits, r_lower);
            end
            default: chg = i_sample_bits[0] != r_held[0];
        endcase
        chg = chg && r_mask[0];
        up  = up && r_mask[2];
        low = low && r_mask[3];
        unique case (i_func)
            FUNC_FORCE:   n_pending = 1'b1;
            FUNC_CONFIRM: n_pending = 1'b0;
            FUNC_SAMPLE: begin
                if (timeout) n_last_ms = i_now_ms;
                if (r_kind == KIND_BOOL) begin
                    if (r_pending || timeout || chg) begin
                        n_held = {31'd0, i_sample_bits[0]};
                        n_pending = i_want_ack;
                        n_out_report = 1'b1;
                        n_out_bytes = BYTES_BOOL;
                    end
                end else if (r_kind == KIND_INT || r_kind == KIND_FLOAT) begin
                    fire = r_pending || timeout || chg || (up && !r_above)
                        || (low && !r_below);
                    if (fire) begin
                        n_held = i_sample_bits;
                        n_pending = i_want_ack;
                        n_out_report = 1'b1;
                        n_out_bytes = BYTES_WORD;
                    end
                    n_above = up;
                    n_below = low;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_INT;
            r_mask <= 4'd0;
            r_period <= 16'd0;
            r_upper <= 32'd0;
            r_lower <= 32'd0;
            r_held <= 32'd0;
            r_last_ms <= 32'd0;
            r_pending <= 1'b0;
            r_above <= 1'b0;
            r_below <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (reg_idx)
                    REG_VALUE_KIND: r_kind <= pwdata[1:0];
                    REG_EVENT_MASK: r_mask <= pwdata[3:0];
                    REG_PERIOD:     r_period <= pwdata[15:0];
                    REG_UPPER:      r_upper <= pwdata;
                    REG_LOWER:      r_lower <= pwdata;
                    default: ;
                endcase
            end
            if (in_xfer) begin
                r_held <= n_held;
                r_last_ms <= n_last_ms;
                r_pending <= n_pending;
                r_above <= n_above;
                r_below <= n_below;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_out_report <= n_out_report;
            r_out_bits <= n_held;
            r_out_bytes <= n_out_bytes;
        end
    end

    assign o_valid = r_out_valid;
    assign o_report = r_out_report;
    assign o_report_bits = r_out_bits;
    assign o_report_bytes = r_out_bytes;

    // a pending result that is not taken must not be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !o_ready)
        else $error("output overwritten");

    // report and byte count agree
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (o_report == (o_report_bytes != BYTES_NONE)))
        else $error("report/bytes mismatch");

    // a boolean report leaves a 0/1 held value
    a_bool_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_report_bytes == BYTES_BOOL) |-> (o_report_bits[31:1] == 31'd0))
        else $error("bool held value wide");

endmodule

FILE: verif/tb_sensor_report_qualifier.sv
module tb_sensor_report_qualifier;
    timeunit 1ns;
    timeprecision 1ps;
    import srq_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [1:0]  i_func;
    logic [31:0] i_sample_bits;
    logic [31:0] i_now_ms;
    logic        i_want_ack;
    logic        o_valid;
    logic        i_ready;
    logic        o_report;
    logic [31:0] o_report_bits;
    logic [2:0]  o_report_bytes;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    sensor_report_qualifier DUT (.*);

    typedef struct packed {
        logic        report;
        logic [31:0] bits;
        logic [2:0]  bytes;
    } verdict_t;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] reg_val;
        logic [1:0]  func;
        logic [31:0] sample;
        logic [31:0] now;
        bit          ack;
        bit          typed;
        verdict_t    typed_res;
    } step_t;

    // shadow configuration and state
    logic [1:0]  cfg_kind;
    logic [3:0]  cfg_mask;
    logic [15:0] cfg_period;
    logic [31:0] cfg_upper;
    logic [31:0] cfg_lower;
    logic [31:0] sh_held;
    logic [31:0] sh_last_ms;
    logic        sh_pending;
    logic        sh_above;
    logic        sh_below;

    verdict_t verdicts_due[$];
    int       errors;
    int       hold_cycles;
    bit       idle_on;
    bit       use_typed;
    verdict_t typed_now;
    step_t    script[$];
    logic [31:0] clock_ms;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #200000;
        $display("sensor_report_qualifier: mismatch");
        $finish;
    end

    function automatic bit flt_nan(logic [31:0] b);
        return (b[30:23] == 8'hff) && (b[22:0] != 0);
    endfunction

    // monotonic ordering key for non-NaN floats; both zeros map together
    function automatic logic [31:0] flt_order(logic [31:0] b);
        if (b[30:0] == 0) return 32'h8000_0000;
        if (b[31]) return ~b;
        return b | 32'h8000_0000;
    endfunction

    function automatic bit num_lt(logic [31:0] a, logic [31:0] b);
        if (cfg_kind == KIND_INT) return $signed(a) < $signed(b);
        if (flt_nan(a) || flt_nan(b)) return 1'b0;
        return flt_order(a) < flt_order(b);
    endfunction

    function automatic bit num_ne(logic [31:0] a, logic [31:0] b);
        if (cfg_kind == KIND_INT) return a != b;
        if (flt_nan(a) || flt_nan(b)) return 1'b1;
        return flt_order(a) != flt_order(b);
    endfunction

    function automatic verdict_t qualify(logic [1:0] func, logic [31:0] sample,
                                         logic [31:0] now, bit ack);
        verdict_t v;
        bit timeout, change, up, low;
        v = '0;
        if (func == FUNC_FORCE) begin
            sh_pending = 1'b1;
        end else if (func == FUNC_CONFIRM) begin
            sh_pending = 1'b0;
        end else if (func == FUNC_SAMPLE) begin
            timeout = 1'b0;
            if (cfg_mask[1] && (now - sh_last_ms) >= 32'(cfg_period) * 32'd1000) begin
                timeout = 1'b1;
                sh_last_ms = now;
            end
            if (cfg_kind == KIND_BOOL) begin
                change = cfg_mask[0] && (sample[0] != sh_held[0]);
                if (sh_pending || timeout || change) begin
                    sh_held = {31'd0, sample[0]};
                    sh_pending = ack;
                    v.report = 1'b1;
                    v.bytes = BYTES_BOOL;
                end
            end else if (cfg_kind == KIND_INT || cfg_kind == KIND_FLOAT) begin
                change = cfg_mask[0] && num_ne(sample, sh_held);
                up = cfg_mask[2] && num_lt(cfg_upper, sample);
                low = cfg_mask[3] && num_lt(sample, cfg_lower);
                if (sh_pending || timeout || change || (up && !sh_above) ||
                    (low && !sh_below)) begin
                    sh_held = sample;
                    sh_pending = ack;
                    v.report = 1'b1;
                    v.bytes = BYTES_WORD;
                end
                sh_above = up;
                sh_below = low;
            end
        end
        v.bits = sh_held;
        return v;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %0t: %s got %h expected %h", $realtime, what, got, want);
        errors++;
    endtask

    // scoreboard: results first, then the transfer accepted at this edge
    always @(posedge i_clk) begin
        verdict_t want, pred;
        if (i_rst_n && o_valid && i_ready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected result, bits", o_report_bits, 0);
            end else begin
                want = verdicts_due.pop_front();
                if (o_report !== want.report)
                    report_mismatch("report", o_report, want.report);
                if (o_report_bits !== want.bits)
                    report_mismatch("report_bits", o_report_bits, want.bits);
                if (o_report_bytes !== want.bytes)
                    report_mismatch("report_bytes", o_report_bytes, want.bytes);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            pred = qualify(i_func, i_sample_bits, i_now_ms, i_want_ack);
            verdicts_due.push_back(use_typed ? typed_now : pred);
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_ready <= !(idle_on && $urandom_range(99) < 9);
        end
    end

    // the typed expectation travels with the item and changes only at a falling edge
    task automatic send_item(logic [1:0] func, logic [31:0] sample, logic [31:0] now,
                             bit ack, bit typed = 0, verdict_t res = '0);
        @(negedge i_clk);
        use_typed = typed;
        typed_now = res;
        while (idle_on && $urandom_range(99) < 9) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_func = func;
        i_sample_bits = sample;
        i_now_ms = now;
        i_want_ack = ack;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_VALUE_KIND: cfg_kind = val[1:0];
            REG_EVENT_MASK: cfg_mask = val[3:0];
            REG_PERIOD:     cfg_period = val[15:0];
            REG_UPPER:      cfg_upper = val;
            REG_LOWER:      cfg_lower = val;
            default: ;
        endcase
    endtask

    function automatic void add_item(logic [1:0] func, logic [31:0] sample,
                                     logic [31:0] now, bit ack, bit typed = 0,
                                     logic rep = 0, logic [31:0] bits = 0,
                                     logic [2:0] bytes = BYTES_NONE);
        step_t s;
        s = '{default: '0};
        s.func = func;
        s.sample = sample;
        s.now = now;
        s.ack = ack;
        s.typed = typed;
        s.typed_res = '{rep, bits, bytes};
        script.push_back(s);
    endfunction

    function automatic void add_cfg(logic [2:0] idx, logic [31:0] val);
        step_t s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        script.push_back(s);
    endfunction

    function automatic logic [31:0] pick_sample();
        logic [31:0] pool[8];
        pool = '{32'h7fc0_0000, 32'h0000_0000, 32'h8000_0000, 32'h7f80_0000,
                 32'hff80_0000, 32'h7fff_ffff, 32'h3f80_0000, 32'hbf80_0000};
        case ($urandom_range(9))
            0, 1, 2: return sh_held;
            3:       return cfg_upper + $urandom_range(2) - 1;
            4:       return cfg_lower + $urandom_range(2) - 1;
            5:       return pool[$urandom_range(7)];
            6:       return $urandom_range(3);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h3f80_0000;
            3: return $urandom_range(200) - 100;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int sent, phase, n, r;
        logic [1:0] f;
        errors = 0;
        hold_cycles = 0;
        idle_on = 1'b1;
        use_typed = 1'b0;
        typed_now = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_func = FUNC_SAMPLE;
        i_sample_bits = '0;
        i_now_ms = '0;
        i_want_ack = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cfg_kind = KIND_INT;
        cfg_mask = '0;
        cfg_period = '0;
        cfg_upper = '0;
        cfg_lower = '0;
        sh_held = '0;
        sh_last_ms = '0;
        sh_pending = 1'b0;
        sh_above = 1'b0;
        sh_below = 1'b0;
        clock_ms = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults: int values, no events enabled
        add_item(FUNC_SAMPLE, 32'd5, 0, 0, 1, 0, 0, BYTES_NONE);
        add_item(FUNC_FORCE, 0, 0, 0, 1, 0, 0, BYTES_NONE);
        add_item(FUNC_SAMPLE, 32'h7fff_ffff, 1, 1, 1, 1, 32'h7fff_ffff, BYTES_WORD);
        add_item(FUNC_SAMPLE, 32'h8000_0000, 2, 0, 1, 1, 32'h8000_0000, BYTES_WORD);
        add_item(FUNC_CONFIRM, 0, 3, 0, 1, 0, 32'h8000_0000, BYTES_NONE);
        add_item(2'd3, 32'hffff_ffff, 4, 1, 1, 0, 32'h8000_0000, BYTES_NONE);
        add_cfg(REG_EVENT_MASK, 32'hf);
        add_cfg(REG_PERIOD, 32'd1);
        add_cfg(REG_UPPER, 32'd100);
        add_cfg(REG_LOWER, 32'hffff_ff9c);
        add_item(FUNC_SAMPLE, 32'h8000_0000, 10, 0);
        add_item(FUNC_SAMPLE, 32'h8000_0000, 20, 0);
        add_item(FUNC_SAMPLE, 32'd101, 30, 0);
        add_item(FUNC_SAMPLE, 32'd101, 1500, 0);
        add_item(FUNC_SAMPLE, 32'd101, 32'hffff_fff0, 0);
        add_item(FUNC_SAMPLE, 32'd101, 32'd1200, 0);
        add_cfg(REG_VALUE_KIND, KIND_FLOAT);
        add_cfg(REG_UPPER, 32'h3f80_0000);
        add_cfg(REG_LOWER, 32'hbf80_0000);
        add_item(FUNC_SAMPLE, 32'h7fc0_0000, 1300, 0);
        add_item(FUNC_SAMPLE, 32'h7fc0_0000, 1400, 0);
        add_item(FUNC_SAMPLE, 32'h0000_0000, 1500, 0);
        add_item(FUNC_SAMPLE, 32'h8000_0000, 1600, 0);
        add_item(FUNC_SAMPLE, 32'h7f80_0000, 1700, 0);
        add_item(FUNC_SAMPLE, 32'hff80_0000, 1800, 0);
        add_cfg(REG_VALUE_KIND, KIND_BOOL);
        add_item(FUNC_SAMPLE, 32'h0000_0001, 1900, 0);
        add_item(FUNC_SAMPLE, 32'hffff_fffe, 2000, 0);
        add_cfg(REG_VALUE_KIND, 32'd3);
        add_item(FUNC_SAMPLE, 32'h1234_5678, 4000, 0);

        foreach (script[k]) begin
            if (script[k].is_cfg) begin
                drain();
                write_reg(script[k].reg_idx, script[k].reg_val);
            end else begin
                send_item(script[k].func, script[k].sample, script[k].now, script[k].ack,
                          script[k].typed, script[k].typed_res);
            end
        end
        clock_ms = 32'd5000;

        sent = 0;
        phase = 0;
        while (sent < 1850) begin
            drain();
            write_reg(REG_VALUE_KIND, (phase % 4 == 3) ? 32'd3 : 32'($urandom_range(2)));
            write_reg(REG_EVENT_MASK, (phase == 1) ? 32'hf : (phase == 2) ? 0 :
                      32'($urandom_range(15)));
            write_reg(REG_PERIOD, (phase == 2) ? 32'hffff : ($urandom_range(3) == 0) ?
                      32'($urandom_range(65535)) : 32'($urandom_range(4)));
            write_reg(REG_UPPER, pick_bound());
            write_reg(REG_LOWER, pick_bound());
            idle_on = (phase != 3);
            n = $urandom_range(60, 140);
            for (int j = 0; j < n; j++) begin
                r = $urandom_range(99);
                f = (r < 75) ? FUNC_SAMPLE : (r < 86) ? FUNC_FORCE :
                    (r < 97) ? FUNC_CONFIRM : 2'd3;
                if ($urandom_range(49) == 0)
                    clock_ms = $urandom;
                else
                    clock_ms = clock_ms + $urandom_range(2500);
                send_item(f, pick_sample(), clock_ms, $urandom_range(1));
                if (phase == 4 && j == 10)
                    hold_cycles = 300;
                sent++;
            end
            phase++;
        end

        drain();
        if (errors == 0) begin
            $display("sensor_report_qualifier: match");
        end else begin
            $display("sensor_report_qualifier: mismatch");
        end
        $finish;
    end
endmodule

FILE: sensor_report_qualifier.f
src/srq_pkg.sv
src/sensor_report_qualifier.sv
verif/tb_sensor_report_qualifier.sv
